### rtl/core/r2m_pkg.sv
// ----------------------------------------------------------------------------
// r2m_pkg: shared constants, types and helpers for the RGBA to mono packer
// Holds the compositing and luma constants, the queue defaults and the
// word type that carries one classified pixel between front and back.
// ----------------------------------------------------------------------------
package r2m_pkg;

  // Queue between classifier and packer
  localparam int QUEUE_DEPTH = 8;
  // Register stages in the classifier pipeline
  localparam int PIPE_STAGES = 3;

  localparam logic [15:0] ROW_WIDTH_RESET = 16'd1;

  // Compositing over white and luma weights
  localparam logic [7:0]  BG_WHITE       = 8'd255;
  localparam logic [7:0]  ROUND_BIAS     = 8'd127;
  localparam logic [7:0]  LUMA_R         = 8'd77;
  localparam logic [7:0]  LUMA_G         = 8'd150;
  localparam logic [7:0]  LUMA_B         = 8'd29;
  localparam logic [15:0] LUMA_THRESHOLD = 16'h8000;
  localparam logic [7:0]  FIRST_BIT_MASK = 8'h80;

  // One classified pixel
  typedef struct packed {
    logic valid;
    logic white;
  } bit_word_t;

  // Exact x / 255 for x below 65280 (composite sums stay at or under 65152)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

### rtl/core/r2m_pix_if.sv
// ----------------------------------------------------------------------------
// r2m_pix_if: pixel channel
// One RGBA pixel per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface r2m_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue,
                  output alpha, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, output ready);
endinterface

### rtl/core/r2m_byte_if.sv
// ----------------------------------------------------------------------------
// r2m_byte_if: packed byte channel
// Eight monochrome pixels per word plus an end-of-row mark.
// ----------------------------------------------------------------------------
interface r2m_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last_of_row;

  modport source (output valid, output packed_byte, output last_of_row,
                  input ready);
  modport sink   (input valid, input packed_byte, input last_of_row,
                  output ready);
endinterface

### rtl/core/r2m_front.sv
// ----------------------------------------------------------------------------
// r2m_front: pixel classifier
// Three-stage pipeline: composite over white, divide by 255, luma and
// threshold. Takes a pixel whenever the queue has room for everything
// already in flight.
// ----------------------------------------------------------------------------
module r2m_front #(
  parameter int DEPTH = r2m_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  r2m_pix_if.sink                    pixel,
  input  logic [$clog2(DEPTH+1)-1:0] level,
  output r2m_pkg::bit_word_t         push
);
  import r2m_pkg::*;

  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam int INF_W = $clog2(PIPE_STAGES + 1);
  localparam int SUM_W = (LVL_W > INF_W ? LVL_W : INF_W) + 1;

  logic        v1, v2, v3;
  logic [15:0] sum_r, sum_g, sum_b;
  logic [7:0]  comp_r, comp_g, comp_b;
  logic        white;
  logic [15:0] bg;
  logic [15:0] luma;
  logic [INF_W-1:0] inflight;
  logic [SUM_W-1:0] committed;
  logic        take;

  // Room check: queued words plus words in the pipeline
  assign inflight    = INF_W'(v1) + INF_W'(v2) + INF_W'(v3);
  assign committed   = SUM_W'(level) + SUM_W'(inflight);
  assign pixel.ready = committed < SUM_W'(DEPTH);
  assign take        = pixel.valid && pixel.ready;

  // Background term shared by all three channels
  assign bg = 16'(BG_WHITE) * 16'(BG_WHITE - pixel.alpha) + 16'(ROUND_BIAS);

  assign luma = 16'(LUMA_R) * 16'(comp_r) + 16'(LUMA_G) * 16'(comp_g)
              + 16'(LUMA_B) * 16'(comp_b);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    sum_r  <= 16'(pixel.red)   * 16'(pixel.alpha) + bg;
    sum_g  <= 16'(pixel.green) * 16'(pixel.alpha) + bg;
    sum_b  <= 16'(pixel.blue)  * 16'(pixel.alpha) + bg;
    comp_r <= div255(sum_r);
    comp_g <= div255(sum_g);
    comp_b <= div255(sum_b);
    white  <= luma >= LUMA_THRESHOLD;
  end

  assign push.valid = v3;
  assign push.white = white;

endmodule

### rtl/core/r2m_bit_fifo.sv
// ----------------------------------------------------------------------------
// r2m_bit_fifo: queue of classified pixels
// Small circular buffer between classifier and packer. The classifier
// never pushes into a full queue, it reserves room before taking a pixel.
// ----------------------------------------------------------------------------
module r2m_bit_fifo #(
  parameter int DEPTH = r2m_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  r2m_pkg::bit_word_t         push,
  input  logic                       pop,
  output r2m_pkg::bit_word_t         head,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import r2m_pkg::*;

  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [DEPTH-1:0] store;
  logic [IDX_W-1:0] wr_ptr, rd_ptr;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      level <= level + LVL_W'(push.valid) - LVL_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      store[wr_ptr] <= push.white;
    end
  end

  assign head.valid = level != '0;
  assign head.white = store[rd_ptr];

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(DEPTH))
    else $error("queue level beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (level < LVL_W'(DEPTH) || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> level != '0)
    else $error("pop from empty queue");

endmodule

### rtl/core/r2m_back.sv
// ----------------------------------------------------------------------------
// r2m_back: bit-row packer
// Takes one classified pixel per cycle from the queue unless the output
// register is stalled, packs it MSB first into the partial byte and loads
// the output register at every eighth pixel or at row end.
// ----------------------------------------------------------------------------
module r2m_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        row_width,
  input  r2m_pkg::bit_word_t head,
  output logic               pop,
  r2m_byte_if.source         mono
);
  import r2m_pkg::*;

  logic [15:0] column_count, column_count_next;
  logic [7:0]  partial_byte, partial_byte_next;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_valid;
  logic [2:0]  pos;
  logic [16:0] col_inc;
  logic [16:0] width;
  logic        row_end;
  logic        emit;
  logic [7:0]  merged;

  // Pop whenever the output register is free or being drained
  assign pop = head.valid && (!out_valid || mono.ready);

  assign pos     = column_count[2:0];
  assign col_inc = {1'b0, column_count} + 17'd1;
  assign width   = (row_width == 16'd0) ? 17'd1 : {1'b0, row_width};
  assign row_end = col_inc >= width;
  assign emit    = (pos == 3'd7) || row_end;
  assign merged  = head.white ? (partial_byte | (FIRST_BIT_MASK >> pos)) : partial_byte;

  // Next packing state
  always_comb begin
    column_count_next = column_count;
    partial_byte_next = partial_byte;
    if (pop) begin
      if (emit) begin
        partial_byte_next = 8'd0;
        column_count_next = row_end ? 16'd0 : col_inc[15:0];
      end else begin
        partial_byte_next = merged;
        column_count_next = col_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 16'd0;
      partial_byte <= 8'd0;
    end else begin
      column_count <= column_count_next;
      partial_byte <= partial_byte_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (mono.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte <= merged;
      out_last <= row_end;
    end
  end

  assign mono.valid       = out_valid;
  assign mono.packed_byte = out_byte;
  assign mono.last_of_row = out_last;

  // Bits at and after the current column are still clear
  a_partial_clean: assert property (@(posedge clk) disable iff (rst)
    (partial_byte & (8'hFF >> pos)) == 8'd0)
    else $error("partial byte has bits past current column");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    pop |-> !(out_valid && !mono.ready))
    else $error("pop while output stalled");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && row_end) |=> (column_count == 16'd0 && out_valid && out_last))
    else $error("row end did not restart column count");

endmodule

### rtl/core/rgba_to_mono_bitrow_packer.sv
// ----------------------------------------------------------------------------
// rgba_to_mono_bitrow_packer: RGBA pixels to packed 1 bpp rows
// Composites each pixel over white, thresholds its luma and packs eight
// pixels per byte, MSB first, flushing a short byte at row end.
// ----------------------------------------------------------------------------
// Sustained rate is one pixel per clock unless the byte side stalls. A
// pixel passes the classifier pipeline (composite, divide by 255, luma and
// threshold), then a DEPTH-entry queue into the packer, which retires one
// pixel per cycle when not stalled and loads its byte into the output
// register. The pixel ready drops only when the queue plus the pipeline
// hold DEPTH words, i.e. when the byte side has been stalled. row_width
// (0 acts as 1) is written through cfg_we/cfg_data; write it only while
// the block is idle, which the block does not enforce. A write does not
// reset the column position. DEPTH must be at least 2, and at least 5 to
// keep one pixel per clock; below that the room check throttles input.
// ----------------------------------------------------------------------------
module rgba_to_mono_bitrow_packer #(
  parameter int DEPTH = r2m_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  r2m_pix_if.sink     pixel,
  r2m_byte_if.source  mono
);
  import r2m_pkg::*;

  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [15:0]      row_width;
  bit_word_t        push;
  bit_word_t        head;
  logic             pop;
  logic [LVL_W-1:0] level;

  // Row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_data;
    end
  end

  r2m_front #(.DEPTH(DEPTH)) u_front (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .level (level),
    .push  (push)
  );

  r2m_bit_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  r2m_back u_back (
    .clk       (clk),
    .rst       (rst),
    .row_width (row_width),
    .head      (head),
    .pop       (pop),
    .mono      (mono)
  );

endmodule
